// ===== hdl/rect_overlap_repulsion_force_unit_macros.svh =====
// assertion helpers shared by the force unit
`ifndef RECT_OVERLAP_REPULSION_FORCE_UNIT_MACROS_SVH
`define RECT_OVERLAP_REPULSION_FORCE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define RORF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RORF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rorf_pkg.sv =====
package rorf_pkg;

  // fixed widths of the stream words
  localparam int FIELD_W    = 16;
  localparam int IN_FIELDS  = 10;
  localparam int IN_DATA_W  = FIELD_W * IN_FIELDS;
  localparam int OUT_W      = 50;
  localparam int OUT_DATA_W = 104;

  // field slots in the input word, lowest first
  localparam int FLD_SELF_LEFT    = 0;
  localparam int FLD_SELF_BOTTOM  = 1;
  localparam int FLD_SELF_RIGHT   = 2;
  localparam int FLD_SELF_TOP     = 3;
  localparam int FLD_SELF_ID      = 4;
  localparam int FLD_OTHER_LEFT   = 5;
  localparam int FLD_OTHER_BOTTOM = 6;
  localparam int FLD_OTHER_RIGHT  = 7;
  localparam int FLD_OTHER_TOP    = 8;
  localparam int FLD_OTHER_ID     = 9;

  // per-item case flags carried down the pipe
  typedef struct packed {
    logic hit;      // ids differ and overlap has positive area
    logic coinc;    // centres coincide
    logic neg_x;    // self centre left of other
    logic neg_y;    // self centre below other
    logic self_lt;  // self id below other id
  } flags_t;

endpackage

// ===== hdl/rorf_root_step.sv =====
module rorf_root_step #(
  parameter int BIT = 0,
  parameter int R_W = 130,
  parameter int P_W = 83,
  parameter int S_W = 35,
  parameter int Q_W = 48
) (
  input  logic           clk,
  input  logic           en,
  input  logic [R_W-1:0] r_i,
  input  logic [P_W-1:0] p_i,
  input  logic [Q_W-1:0] q_i,
  input  logic [S_W-1:0] s_i,
  output logic [R_W-1:0] r_o,
  output logic [P_W-1:0] p_o,
  output logic [Q_W-1:0] q_o
);

  localparam int D_W = R_W + 2;

  logic [D_W-1:0] delta;
  logic           take;
  logic [R_W-1:0] r_nxt, r_r;
  logic [P_W-1:0] p_nxt, p_r;
  logic [Q_W-1:0] q_nxt, q_r;

  // (q + 2^b)^2 s - q^2 s = 2^(b+1) q s + 2^(2b) s
  always_comb begin
    delta = (D_W'(p_i) << (BIT + 1)) + (D_W'(s_i) << (2 * BIT));
    take  = (delta <= D_W'(r_i));
    r_nxt = take ? (r_i - R_W'(delta)) : r_i;
    p_nxt = take ? (p_i + (P_W'(s_i) << BIT)) : p_i;
    q_nxt = take ? (q_i | (Q_W'(1) << BIT)) : q_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
  end

  assign r_o = r_r;
  assign p_o = p_r;
  assign q_o = q_r;

endmodule

// ===== hdl/rect_overlap_repulsion_force_unit.sv =====
// throughput: one word per cycle while the skid register is empty (the whole pipe
//   stalls while it is full); five arithmetic stages, then one restoring root-divide
//   stage per quotient bit, then the output register
// a two-entry output (register plus skid) lets the pipe run while a result waits
// reset: synchronous active-low rst_n clears all valid bits; data registers are not reset
`include "rect_overlap_repulsion_force_unit_macros.svh"

module rect_overlap_repulsion_force_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // self_left, self_bottom, self_right, self_top, self_id,
  // other_left, other_bottom, other_right, other_top, other_id
  input  logic [rorf_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // force_x, force_y, zero fill
  output logic [rorf_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int C      = COORD_BITS;
  localparam int AW     = C + 1;          // centre-sum difference magnitude
  localparam int AREA_W = 2 * C;
  localparam int SQA_W  = 2 * C + 2;      // squared difference
  localparam int S_W    = 2 * C + 3;      // sum of squares
  localparam int A2_W   = 4 * C;          // area squared
  localparam int HALF_W = 2 * C;
  localparam int PP_W   = HALF_W + SQA_W;
  localparam int M_W    = A2_W + SQA_W;
  localparam int R_W    = M_W + 2 * FRAC_BITS;
  localparam int Q_W    = 2 * C + FRAC_BITS;
  localparam int P_W    = Q_W + S_W;
  localparam int OW     = rorf_pkg::OUT_W;
  localparam int FW     = rorf_pkg::FIELD_W;

  logic en;

  // ---------------- stage a: intersection, centre differences ----------------
  logic [C-1:0]  sl, sb, sr, st, ol, ob, orr, ot;
  logic [FW-1:0] sid, oid;
  logic [C-1:0]  lx, ux, ly, uy;
  logic [AW-1:0] sum_sx, sum_ox, sum_sy, sum_oy;
  rorf_pkg::flags_t fl_a_nxt;

  logic              va_r;
  logic [C-1:0]      w_a_r, h_a_r;
  logic [AW-1:0]     ax_a_r, ay_a_r;
  rorf_pkg::flags_t  fl_a_r;
  logic [AW-1:0]     ax_a_nxt, ay_a_nxt;

  always_comb begin
    sl  = C'(in_tdata[rorf_pkg::FLD_SELF_LEFT    * FW +: FW]);
    sb  = C'(in_tdata[rorf_pkg::FLD_SELF_BOTTOM  * FW +: FW]);
    sr  = C'(in_tdata[rorf_pkg::FLD_SELF_RIGHT   * FW +: FW]);
    st  = C'(in_tdata[rorf_pkg::FLD_SELF_TOP     * FW +: FW]);
    sid = in_tdata[rorf_pkg::FLD_SELF_ID * FW +: FW];
    ol  = C'(in_tdata[rorf_pkg::FLD_OTHER_LEFT   * FW +: FW]);
    ob  = C'(in_tdata[rorf_pkg::FLD_OTHER_BOTTOM * FW +: FW]);
    orr = C'(in_tdata[rorf_pkg::FLD_OTHER_RIGHT  * FW +: FW]);
    ot  = C'(in_tdata[rorf_pkg::FLD_OTHER_TOP    * FW +: FW]);
    oid = in_tdata[rorf_pkg::FLD_OTHER_ID * FW +: FW];

    lx = (sl > ol) ? sl : ol;
    ux = (sr < orr) ? sr : orr;
    ly = (sb > ob) ? sb : ob;
    uy = (st < ot) ? st : ot;

    // doubled centres, compared as sums
    sum_sx = AW'(sl) + AW'(sr);
    sum_ox = AW'(ol) + AW'(orr);
    sum_sy = AW'(sb) + AW'(st);
    sum_oy = AW'(ob) + AW'(ot);

    fl_a_nxt.neg_x   = (sum_ox > sum_sx);
    fl_a_nxt.neg_y   = (sum_oy > sum_sy);
    ax_a_nxt = fl_a_nxt.neg_x ? (sum_ox - sum_sx) : (sum_sx - sum_ox);
    ay_a_nxt = fl_a_nxt.neg_y ? (sum_oy - sum_sy) : (sum_sy - sum_oy);
    fl_a_nxt.coinc   = (sum_sx == sum_ox) && (sum_sy == sum_oy);
    fl_a_nxt.hit     = (sid != oid) && (lx < ux) && (ly < uy);
    fl_a_nxt.self_lt = (sid < oid);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_a_r  <= ux - lx;
      h_a_r  <= uy - ly;
      ax_a_r <= ax_a_nxt;
      ay_a_r <= ay_a_nxt;
      fl_a_r <= fl_a_nxt;
    end
  end

  // ---------------- stage b: area and squared differences ----------------
  logic                 vb_r;
  logic [AREA_W-1:0]    area_b_r;
  logic [SQA_W-1:0]     ax2_b_r, ay2_b_r;
  rorf_pkg::flags_t     fl_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      area_b_r <= AREA_W'(w_a_r) * AREA_W'(h_a_r);
      ax2_b_r  <= SQA_W'(ax_a_r) * SQA_W'(ax_a_r);
      ay2_b_r  <= SQA_W'(ay_a_r) * SQA_W'(ay_a_r);
      fl_b_r   <= fl_a_r;
    end
  end

  // ---------------- stage c: area squared, sum of squares ----------------
  logic                 vc_r;
  logic [AREA_W-1:0]    area_c_r;
  logic [A2_W-1:0]      area2_c_r;
  logic [SQA_W-1:0]     ax2_c_r, ay2_c_r;
  logic [S_W-1:0]       s_c_r;
  rorf_pkg::flags_t     fl_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      area_c_r  <= area_b_r;
      area2_c_r <= A2_W'(area_b_r) * A2_W'(area_b_r);
      ax2_c_r   <= ax2_b_r;
      ay2_c_r   <= ay2_b_r;
      s_c_r     <= S_W'(ax2_b_r) + S_W'(ay2_b_r);
      fl_c_r    <= fl_b_r;
    end
  end

  // ---------------- stage d: partial products of area^2 * d^2 ----------------
  logic                 vd_r;
  logic [AREA_W-1:0]    area_d_r;
  logic [PP_W-1:0]      ppx_lo_r, ppx_hi_r, ppy_lo_r, ppy_hi_r;
  logic [S_W-1:0]       s_d_r;
  rorf_pkg::flags_t     fl_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      area_d_r <= area_c_r;
      ppx_lo_r <= PP_W'(area2_c_r[HALF_W-1:0])      * PP_W'(ax2_c_r);
      ppx_hi_r <= PP_W'(area2_c_r[A2_W-1:HALF_W])   * PP_W'(ax2_c_r);
      ppy_lo_r <= PP_W'(area2_c_r[HALF_W-1:0])      * PP_W'(ay2_c_r);
      ppy_hi_r <= PP_W'(area2_c_r[A2_W-1:HALF_W])   * PP_W'(ay2_c_r);
      s_d_r    <= s_c_r;
      fl_d_r   <= fl_c_r;
    end
  end

  // ---------------- stage e: squared scaled numerator ----------------
  logic                 ve_r;
  logic [AREA_W-1:0]    area_e_r;
  logic [R_W-1:0]       rx_e_r, ry_e_r;
  logic [S_W-1:0]       s_e_r;
  rorf_pkg::flags_t     fl_e_r;
  logic [M_W-1:0]       mx_nxt, my_nxt;

  always_comb begin
    mx_nxt = (M_W'(ppx_hi_r) << HALF_W) + M_W'(ppx_lo_r);
    my_nxt = (M_W'(ppy_hi_r) << HALF_W) + M_W'(ppy_lo_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area_e_r <= area_d_r;
      rx_e_r   <= R_W'(mx_nxt) << (2 * FRAC_BITS);
      ry_e_r   <= R_W'(my_nxt) << (2 * FRAC_BITS);
      s_e_r    <= s_d_r;
      fl_e_r   <= fl_d_r;
    end
  end

  // ---------------- root-divide stages, one quotient bit each ----------------
  // q = largest value with q^2 * s <= numerator^2, msb first
  logic [R_W-1:0]    rx_w [Q_W];
  logic [R_W-1:0]    ry_w [Q_W];
  logic [P_W-1:0]    px_w [Q_W];
  logic [P_W-1:0]    py_w [Q_W];
  logic [Q_W-1:0]    qx_w [Q_W];
  logic [Q_W-1:0]    qy_w [Q_W];

  logic              rv_r   [Q_W];
  logic [S_W-1:0]    s_r    [Q_W];
  logic [AREA_W-1:0] area_r [Q_W];
  rorf_pkg::flags_t  fl_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_root
    logic [R_W-1:0] rx_in, ry_in;
    logic [P_W-1:0] px_in, py_in;
    logic [Q_W-1:0] qx_in, qy_in;
    logic [S_W-1:0] s_in;

    if (k == 0) begin : g_first
      assign rx_in = rx_e_r;
      assign ry_in = ry_e_r;
      assign px_in = '0;
      assign py_in = '0;
      assign qx_in = '0;
      assign qy_in = '0;
      assign s_in  = s_e_r;
    end else begin : g_rest
      assign rx_in = rx_w[k-1];
      assign ry_in = ry_w[k-1];
      assign px_in = px_w[k-1];
      assign py_in = py_w[k-1];
      assign qx_in = qx_w[k-1];
      assign qy_in = qy_w[k-1];
      assign s_in  = s_r[k-1];
    end

    rorf_root_step #(
      .BIT (Q_W - 1 - k),
      .R_W (R_W),
      .P_W (P_W),
      .S_W (S_W),
      .Q_W (Q_W)
    ) u_step_x (
      .clk (clk),
      .en  (en),
      .r_i (rx_in),
      .p_i (px_in),
      .q_i (qx_in),
      .s_i (s_in),
      .r_o (rx_w[k]),
      .p_o (px_w[k]),
      .q_o (qx_w[k])
    );

    rorf_root_step #(
      .BIT (Q_W - 1 - k),
      .R_W (R_W),
      .P_W (P_W),
      .S_W (S_W),
      .Q_W (Q_W)
    ) u_step_y (
      .clk (clk),
      .en  (en),
      .r_i (ry_in),
      .p_i (py_in),
      .q_i (qy_in),
      .s_i (s_in),
      .r_o (ry_w[k]),
      .p_o (py_w[k]),
      .q_o (qy_w[k])
    );
  end

  // side data rides alongside the root stages
  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]    <= s_e_r;
      area_r[0] <= area_e_r;
      fl_r[0]   <= fl_e_r;
      for (int i = 1; i < Q_W; i++) begin
        s_r[i]    <= s_r[i-1];
        area_r[i] <= area_r[i-1];
        fl_r[i]   <= fl_r[i-1];
      end
    end
  end

  // ---------------- valid bits, global advance ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      for (int i = 0; i < Q_W; i++) begin
        rv_r[i] <= 1'b0;
      end
    end else if (en) begin
      va_r    <= in_tvalid;
      vb_r    <= va_r;
      vc_r    <= vb_r;
      vd_r    <= vc_r;
      ve_r    <= vd_r;
      rv_r[0] <= ve_r;
      for (int i = 1; i < Q_W; i++) begin
        rv_r[i] <= rv_r[i-1];
      end
    end
  end

  // ---------------- result select ----------------
  logic [OW-1:0] fx_nxt, fy_nxt, mag_c;
  rorf_pkg::flags_t fl_last;

  always_comb begin
    fl_last = fl_r[Q_W-1];
    mag_c   = OW'(area_r[Q_W-1]) << FRAC_BITS;
    if (!fl_last.hit) begin
      fx_nxt = '0;
      fy_nxt = '0;
    end else if (fl_last.coinc) begin
      // centres on top of each other: push along x by id order
      fx_nxt = fl_last.self_lt ? (OW'(0) - mag_c) : mag_c;
      fy_nxt = '0;
    end else begin
      fx_nxt = fl_last.neg_x ? (OW'(0) - OW'(qx_w[Q_W-1])) : OW'(qx_w[Q_W-1]);
      fy_nxt = fl_last.neg_y ? (OW'(0) - OW'(qy_w[Q_W-1])) : OW'(qy_w[Q_W-1]);
    end
  end

  // ---------------- output register plus skid ----------------
  logic          out_v_r, skid_v_r;
  logic [OW-1:0] out_fx_r, out_fy_r, skid_fx_r, skid_fy_r;
  logic          push, pop;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign push      = en && rv_r[Q_W-1];
  assign pop       = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_fx_r <= skid_fx_r;
        out_fy_r <= skid_fy_r;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_fx_r <= fx_nxt;
        out_fy_r <= fy_nxt;
      end else begin
        skid_fx_r <= fx_nxt;
        skid_fy_r <= fy_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(rorf_pkg::OUT_DATA_W - 2 * OW)'(0), out_fy_r, out_fx_r};

  // ---------------- checks ----------------
  `RORF_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid full with output empty")
  `RORF_ASSERT_NXT(a_miss_gives_zero, push && !fl_last.hit && (!out_v_r || pop), out_tdata == '0, "missed pair gave nonzero force")
  `RORF_ASSERT_NXT(a_coinc_no_y, push && fl_last.coinc && (!out_v_r || pop), out_fy_r == '0, "coincident centres gave y force")
  `RORF_ASSERT_IMP(a_stall_only_full, !in_tready, out_v_r && skid_v_r, "input stalled with room left")

endmodule

// ===== tb/sv/tb_rect_overlap_repulsion_force_unit.sv =====
`timescale 1ns / 100ps

module tb_rect_overlap_repulsion_force_unit;

  localparam int FRAC     = 16;
  localparam int N_RANDOM = 550;
  localparam int LIMIT    = 400000;
  localparam int DRAIN    = 80;   // a bit over the pipe latency

  // one input word, first field in the lowest bits
  typedef struct packed {
    logic [15:0] other_id;
    logic [15:0] other_top;
    logic [15:0] other_right;
    logic [15:0] other_bottom;
    logic [15:0] other_left;
    logic [15:0] self_id;
    logic [15:0] self_top;
    logic [15:0] self_right;
    logic [15:0] self_bottom;
    logic [15:0] self_left;
  } rect_pair_t;

  typedef struct packed {
    logic [rorf_pkg::OUT_W-1:0] force_y;
    logic [rorf_pkg::OUT_W-1:0] force_x;
  } force_t;

  // floor(area * num * 2^FRAC / sqrt(sq)) by bitwise search on q^2 * sq <= n^2
  function automatic logic [63:0] unit_scaled(input logic [63:0] area, input logic [63:0] num,
                                              input logic [63:0] sq);
    logic [255:0] n, n2, s, q, lhs;
    n = 256'(area);
    n = n * 256'(num);
    n = n << FRAC;
    n2 = n * n;
    s = 256'(sq);
    q = '0;
    for (int b = 47; b >= 0; b--) begin
      q[b] = 1'b1;
      lhs = q * q * s;
      if (lhs > n2) q[b] = 1'b0;
    end
    return q[63:0];
  endfunction

  function automatic logic [rorf_pkg::OUT_W-1:0] apply_sign(input logic [63:0] mag,
                                                            input logic neg);
    logic [63:0] v;
    v = neg ? (64'd0 - mag) : mag;
    return v[rorf_pkg::OUT_W-1:0];
  endfunction

  function automatic force_t predict_force(input rect_pair_t p);
    force_t r;
    longint lx, ux, ly, uy, dx, dy;
    logic [63:0] area, ax, ay, sq;
    r = '0;
    if (p.self_id == p.other_id) return r;
    lx = longint'((p.self_left > p.other_left) ? p.self_left : p.other_left);
    ux = longint'((p.self_right < p.other_right) ? p.self_right : p.other_right);
    ly = longint'((p.self_bottom > p.other_bottom) ? p.self_bottom : p.other_bottom);
    uy = longint'((p.self_top < p.other_top) ? p.self_top : p.other_top);
    if (!(lx < ux && ly < uy)) return r;
    area = (ux - lx) * (uy - ly);
    dx = longint'(p.self_left) + longint'(p.self_right)
       - longint'(p.other_left) - longint'(p.other_right);
    dy = longint'(p.self_bottom) + longint'(p.self_top)
       - longint'(p.other_bottom) - longint'(p.other_top);
    if (dx == 0 && dy == 0) begin
      // coincident centres: push along x, direction set by id order
      r.force_x = apply_sign(area << FRAC, p.self_id < p.other_id);
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax + ay * ay;
    r.force_x = apply_sign(unit_scaled(area, ax, sq), dx < 0);
    r.force_y = apply_sign(unit_scaled(area, ay, sq), dy < 0);
    return r;
  endfunction

  class force_scoreboard;
    force_t pending_forces[$];
    int errors = 0;

    task report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    function void note_pair(input rect_pair_t p);
      pending_forces.push_back(predict_force(p));
    endfunction

    task check_force(input force_t got, input logic [rorf_pkg::OUT_DATA_W-1:0] raw);
      force_t want;
      if (pending_forces.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pending_forces.pop_front();
      if (got.force_x !== want.force_x)
        report($sformatf("force_x got %h want %h", got.force_x, want.force_x));
      if (got.force_y !== want.force_y)
        report($sformatf("force_y got %h want %h", got.force_y, want.force_y));
      if (raw[rorf_pkg::OUT_DATA_W-1:2*rorf_pkg::OUT_W] !== '0)
        report("fill bits not zero");
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [rorf_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [rorf_pkg::OUT_DATA_W-1:0] out_tdata;   // force_x, force_y, zero fill

  force_scoreboard sb = new();
  int  accepted = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;       // last part of the run: no idling on either side
  bit  long_hold = 1'b0;   // request for one long receiver stall

  rect_pair_t directed[$];

  always #4 clk = ~clk;

  rect_overlap_repulsion_force_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // both channels sampled at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_pair(rect_pair_t'(in_tdata));
      accepted++;
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_force(force_t'(out_tdata[2*rorf_pkg::OUT_W-1:0]), out_tdata);
  end

  function automatic rect_pair_t mk(input int sl, sb_, sr, st, sid, ol, ob, orr, ot, oid);
    rect_pair_t p;
    p.self_left = 16'(sl);    p.self_bottom = 16'(sb_);  p.self_right = 16'(sr);
    p.self_top = 16'(st);     p.self_id = 16'(sid);      p.other_left = 16'(ol);
    p.other_bottom = 16'(ob); p.other_right = 16'(orr);  p.other_top = 16'(ot);
    p.other_id = 16'(oid);
    return p;
  endfunction

  function automatic int clamp16(input int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // mostly overlapping pairs, some of every special case, some pure noise
  function automatic rect_pair_t random_pair();
    rect_pair_t p;
    int kind, span, x, y, w, h, ox, oy, ow, oh;
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 9) == 0) ? 40000 : (($urandom_range(0, 2) == 0) ? 2000 : 60);
    x = $urandom_range(0, 65535);
    y = $urandom_range(0, 65535);
    w = $urandom_range(1, span);
    h = $urandom_range(1, span);
    ox = x + int'($urandom_range(0, 2 * w)) - w;
    oy = y + int'($urandom_range(0, 2 * h)) - h;
    ow = $urandom_range(1, span);
    oh = $urandom_range(1, span);
    p = mk(clamp16(x), clamp16(y), clamp16(x + w), clamp16(y + h), $urandom_range(0, 65535),
           clamp16(ox), clamp16(oy), clamp16(ox + ow), clamp16(oy + oh),
           $urandom_range(0, 65535));
    if (kind < 12) begin
      p = rect_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (kind < 20) begin
      p.other_id = p.self_id;
    end else if (kind < 30) begin
      // same centre, sizes differ by even amounts
      p.other_left = 16'(clamp16(x - 2));  p.other_right = 16'(clamp16(x + w + 2));
      p.other_bottom = 16'(y);             p.other_top = 16'(clamp16(y + h));
      if (x < 2 || x + w + 2 > 65535 || y + h > 65535) p.other_left = p.self_left;
      if (p.other_left == p.self_left) begin
        p.other_right = p.self_right;  p.other_bottom = p.self_bottom;
        p.other_top = p.self_top;
      end
    end else if (kind < 34) begin
      // touching on the right edge
      p.other_left = p.self_right;
    end
    return p;
  endfunction

  task automatic send_pair(input rect_pair_t p);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off, none at the end
  initial begin
    int n;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (quiet) begin
        out_tready = 1'b1;
        @(negedge clk);
      end else if (long_hold) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        n = $urandom_range(1, 18);
        out_tready = ($urandom_range(0, 2) != 0);
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    // extremes, every special case
    directed.push_back(mk(0, 0, 65535, 65535, 0, 0, 0, 65535, 65535, 65535));   // full cover
    directed.push_back(mk(0, 0, 65535, 65535, 65535, 0, 0, 65535, 65535, 0));
    directed.push_back(mk(0, 0, 65535, 65535, 1, 1, 1, 65535, 65535, 2));       // big area
    directed.push_back(mk(1, 1, 65535, 65535, 3, 0, 0, 65535, 65535, 2));
    directed.push_back(mk(10, 10, 20, 20, 7, 10, 10, 20, 20, 7));               // same id
    directed.push_back(mk(10, 10, 20, 20, 1, 20, 10, 30, 20, 2));               // touching x
    directed.push_back(mk(10, 10, 20, 20, 1, 10, 20, 20, 30, 2));               // touching y
    directed.push_back(mk(20, 10, 10, 20, 1, 5, 5, 30, 30, 2));                 // reversed x
    directed.push_back(mk(10, 20, 20, 10, 1, 5, 5, 30, 30, 2));                 // reversed y
    directed.push_back(mk(10, 10, 20, 20, 1, 12, 12, 18, 18, 2));               // centres equal
    directed.push_back(mk(10, 10, 20, 20, 9, 12, 12, 18, 18, 2));
    directed.push_back(mk(10, 10, 20, 20, 1, 15, 10, 25, 20, 2));               // pure -x
    directed.push_back(mk(10, 10, 20, 20, 1, 10, 5, 20, 15, 2));                // pure +y
    directed.push_back(mk(10, 10, 20, 20, 1, 13, 14, 23, 24, 2));               // diagonal
    directed.push_back(mk(0, 0, 3, 3, 0, 1, 2, 4, 5, 65535));
    directed.push_back(mk(65532, 65530, 65535, 65535, 4, 65534, 65531, 65535, 65534, 5));
    directed.push_back(mk(0, 0, 1, 1, 0, 0, 0, 1, 1, 1));
    directed.push_back(mk(0, 0, 65535, 1, 2, 1, 0, 65534, 1, 1));
    directed.push_back(mk(40000, 0, 40001, 65535, 5, 0, 0, 65535, 65535, 6));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_pair(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 80) long_hold = 1'b1;     // sender keeps offering while output is held
      if (i == N_RANDOM - 90) quiet = 1'b1;
      send_pair(random_pair());
    end
    in_tvalid = 1'b0;

    while (sb.pending_forces.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    if (sb.errors == 0 && sb.pending_forces.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
